// ----- rtl/coc_pkg.sv -----
// Shared types and constants of the container order classifier.
`timescale 1ns / 1ps

package coc_pkg;

    typedef enum logic [2:0] {
        VERDICT_IMPOSSIBLE = 3'd0,
        VERDICT_NOT_SURE   = 3'd1,
        VERDICT_STACK      = 3'd2,
        VERDICT_QUEUE      = 3'd3,
        VERDICT_PRIO_QUEUE = 3'd4
    } t_verdict;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // Bit positions of the consistent flags.
    localparam int OK_STACK = 0;
    localparam int OK_FIFO  = 1;
    localparam int OK_HEAP  = 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_HEAP,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        H_IDLE,
        H_UP,
        H_PUT,
        H_TOP,
        H_LAST,
        H_C1,
        H_C2
    } t_heap_state;

    typedef struct packed {
        logic start;
        logic pop;
        logic clear;
    } t_heap_cmd;

    typedef struct packed {
        logic done;
        logic fail;
        logic ovf;
    } t_heap_rsp;

endpackage

// ----- rtl/container_order_classifier.sv -----
// Top level of the container order classifier: stack, FIFO and heap checker.
`timescale 1ns / 1ps

// Each transaction on the slave side is one push or pop of a trace. The block
// runs a stack, a FIFO and a max-heap side by side, each in its own RAM, and
// returns one transaction per input with the verdict of the trace so far. An
// item goes straight from the execute state to the finish state when only the
// stack and FIFO are updated, and also when the heap answers at once (empty on
// a pop, empty or full on a push). Otherwise it waits for the heap unit's walk:
// a push climbs one level per H_UP step, a pop sinks one level per H_C1/H_C2
// pair, the longest item being a pop from a full heap. One item is processed
// at a time; a finished result sits in the output register while the next item
// is taken. After an item with tlast set, all counts and flags return to their
// reset values. Pushes beyond CAPACITY are dropped and raise the sticky
// overflow bit for the rest of the trace.

module container_order_classifier
    import coc_pkg::*;
#(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [0] func, [16:1] value, [23:17] zero
    input  logic        s_axis_tlast,  // last operation of the trace
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [2:0] verdict, [3] overflow, [7:4] zero
    output logic        m_axis_tlast   // trace_end
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_state r_state, n_state;
    logic                  r_func, n_func;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic                  r_last, n_last;
    logic [2:0]            r_ok, n_ok;
    logic                  r_ovf, n_ovf;
    logic [CW-1:0]         r_scnt, n_scnt;
    logic [AW-1:0]         r_fhead, n_fhead;
    logic [AW-1:0]         r_ftail, n_ftail;
    logic [CW-1:0]         r_fcnt, n_fcnt;
    logic                  r_out_valid, n_out_valid;
    t_verdict              r_verdict, n_verdict;
    logic                  r_out_ovf, n_out_ovf;
    logic                  r_out_last, n_out_last;

    logic                  s_we, f_we;
    logic [AW-1:0]         s_raddr;
    logic [VALUE_BITS-1:0] s_rdata, f_rdata;
    t_heap_cmd             h_cmd;
    t_heap_rsp             h_rsp;
    logic                  accept;
    logic                  out_free;

    // The stack top and FIFO front are read every cycle from the current
    // pointers, which do not move between acceptance and the execute cycle.
    assign s_raddr = AW'(r_scnt - CW'(1));

    coc_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(CAPACITY)
    ) u_stack_ram (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(AW'(r_scnt)),
        .i_wdata(r_val),
        .i_raddr(s_raddr),
        .o_rdata(s_rdata)
    );

    coc_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(CAPACITY)
    ) u_fifo_ram (
        .i_clk  (i_clk),
        .i_we   (f_we),
        .i_waddr(r_ftail),
        .i_wdata(r_val),
        .i_raddr(r_fhead),
        .o_rdata(f_rdata)
    );

    coc_heap #(
        .CAPACITY  (CAPACITY),
        .VALUE_BITS(VALUE_BITS)
    ) u_heap (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (h_cmd),
        .i_value(r_val),
        .o_rsp  (h_rsp)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // The heap is started in the execute cycle and may answer in that same
    // cycle; it is cleared together with the other state at the end of a trace.
    assign h_cmd.start = (r_state == S_EXEC) && r_ok[OK_HEAP];
    assign h_cmd.pop   = r_func;
    assign h_cmd.clear = (r_state == S_FIN) && out_free && r_last;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_ovf, r_verdict};
    assign m_axis_tlast  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ok        <= 3'b111;
            r_ovf       <= 1'b0;
            r_scnt      <= '0;
            r_fhead     <= '0;
            r_ftail     <= '0;
            r_fcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ok        <= n_ok;
            r_ovf       <= n_ovf;
            r_scnt      <= n_scnt;
            r_fhead     <= n_fhead;
            r_ftail     <= n_ftail;
            r_fcnt      <= n_fcnt;
            r_out_valid <= n_out_valid;
        end
        r_func     <= n_func;
        r_val      <= n_val;
        r_last     <= n_last;
        r_verdict  <= n_verdict;
        r_out_ovf  <= n_out_ovf;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_val       = r_val;
        n_last      = r_last;
        n_ok        = r_ok;
        n_ovf       = r_ovf;
        n_scnt      = r_scnt;
        n_fhead     = r_fhead;
        n_ftail     = r_ftail;
        n_fcnt      = r_fcnt;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_verdict   = r_verdict;
        n_out_ovf   = r_out_ovf;
        n_out_last  = r_out_last;
        s_we        = 1'b0;
        f_we        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_func  = s_axis_tdata[0];
                    n_val   = VALUE_BITS'(s_axis_tdata[16:1]);
                    n_last  = s_axis_tlast;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_func == FUNC_PUSH) begin
                    if (r_ok[OK_STACK]) begin
                        if (r_scnt >= CW'(CAPACITY)) begin
                            n_ovf = 1'b1;
                        end else begin
                            s_we   = 1'b1;
                            n_scnt = r_scnt + CW'(1);
                        end
                    end
                    if (r_ok[OK_FIFO]) begin
                        if (r_fcnt >= CW'(CAPACITY)) begin
                            n_ovf = 1'b1;
                        end else begin
                            f_we    = 1'b1;
                            n_ftail = (r_ftail == AW'(CAPACITY - 1)) ? '0
                                                                     : r_ftail + AW'(1);
                            n_fcnt  = r_fcnt + CW'(1);
                        end
                    end
                end else begin
                    if (r_ok[OK_STACK]) begin
                        if (r_scnt == '0 || s_rdata != r_val) begin
                            n_ok[OK_STACK] = 1'b0;
                        end else begin
                            n_scnt = r_scnt - CW'(1);
                        end
                    end
                    if (r_ok[OK_FIFO]) begin
                        if (r_fcnt == '0 || f_rdata != r_val) begin
                            n_ok[OK_FIFO] = 1'b0;
                        end else begin
                            n_fhead = (r_fhead == AW'(CAPACITY - 1)) ? '0
                                                                     : r_fhead + AW'(1);
                            n_fcnt  = r_fcnt - CW'(1);
                        end
                    end
                end
                if (r_ok[OK_HEAP]) begin
                    // An empty or full heap answers in the cycle it is started.
                    if (h_rsp.done) begin
                        if (h_rsp.fail) begin
                            n_ok[OK_HEAP] = 1'b0;
                        end
                        if (h_rsp.ovf) begin
                            n_ovf = 1'b1;
                        end
                        n_state = S_FIN;
                    end else begin
                        n_state = S_HEAP;
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_HEAP: begin
                if (h_rsp.done) begin
                    if (h_rsp.fail) begin
                        n_ok[OK_HEAP] = 1'b0;
                    end
                    if (h_rsp.ovf) begin
                        n_ovf = 1'b1;
                    end
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ovf   = r_ovf;
                    n_out_last  = r_last;
                    unique case (r_ok)
                        3'b000:  n_verdict = VERDICT_IMPOSSIBLE;
                        3'b001:  n_verdict = VERDICT_STACK;
                        3'b010:  n_verdict = VERDICT_QUEUE;
                        3'b100:  n_verdict = VERDICT_PRIO_QUEUE;
                        default: n_verdict = VERDICT_NOT_SURE;
                    endcase
                    if (r_last) begin
                        // End of trace: everything returns to its reset values.
                        n_ok        = 3'b111;
                        n_ovf       = 1'b0;
                        n_scnt      = '0;
                        n_fhead     = '0;
                        n_ftail     = '0;
                        n_fcnt      = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scnt <= CW'(CAPACITY))
        else $error("stack count exceeds capacity");

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= CW'(CAPACITY))
        else $error("fifo count exceeds capacity");

    a_heap_done_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        h_rsp.done |-> (r_state == S_HEAP || r_state == S_EXEC))
        else $error("heap unit finished outside of a heap step");

    a_flags_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == S_FIN && r_last) |=> ((r_ok & ~$past(r_ok)) == 3'b000))
        else $error("consistent flag set again within a trace");
`endif

endmodule

// ----- rtl/coc_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module coc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/coc_heap.sv -----
// Max-heap unit: sift-up insert and sift-down remove over one RAM.
`timescale 1ns / 1ps

module coc_heap
    import coc_pkg::*;
#(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_heap_cmd             i_cmd,
    input  logic [VALUE_BITS-1:0] i_value,
    output t_heap_rsp             o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;

    t_heap_state r_hs, n_hs;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_i, n_i;
    logic [VALUE_BITS-1:0] r_v, n_v;
    logic [VALUE_BITS-1:0] r_cv, n_cv;

    logic                  we;
    logic [AW-1:0]         waddr;
    logic [VALUE_BITS-1:0] wdata;
    logic [AW-1:0]         raddr;
    logic [VALUE_BITS-1:0] rdata;

    logic [AW-1:0]         par_i;
    logic [AW-1:0]         par_p;
    logic [XW-1:0]         c_x;
    logic [XW-1:0]         c1_x;
    logic [XW-1:0]         nc_x;
    logic [XW-1:0]         cnt_x;
    logic                  take_right;
    logic [VALUE_BITS-1:0] best_v;
    logic [AW-1:0]         best_i;

    coc_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hs  <= H_IDLE;
            r_cnt <= '0;
        end else begin
            r_hs  <= n_hs;
            r_cnt <= n_cnt;
        end
        r_i  <= n_i;
        r_v  <= n_v;
        r_cv <= n_cv;
    end

    // Index arithmetic for parent and children of the current slot.
    assign par_i      = (r_i - AW'(1)) >> 1;
    assign par_p      = (par_i - AW'(1)) >> 1;
    assign c_x        = XW'({r_i, 1'b1});
    assign c1_x       = c_x + XW'(1);
    assign cnt_x      = XW'(r_cnt);
    assign take_right = (r_hs == H_C2) && (rdata > r_cv);
    assign best_v     = (r_hs == H_C2) ? (take_right ? rdata : r_cv) : rdata;
    assign best_i     = take_right ? c1_x[AW-1:0] : c_x[AW-1:0];
    assign nc_x       = XW'({best_i, 1'b1});

    always_comb begin
        n_hs  = r_hs;
        n_cnt = r_cnt;
        n_i   = r_i;
        n_v   = r_v;
        n_cv  = r_cv;
        we    = 1'b0;
        waddr = r_i;
        wdata = r_v;
        raddr = '0;
        o_rsp = '0;
        unique case (r_hs)
            H_IDLE: begin
                if (i_cmd.clear) begin
                    n_cnt = '0;
                end else if (i_cmd.start) begin
                    n_v = i_value;
                    if (i_cmd.pop == FUNC_PUSH) begin
                        if (r_cnt >= CW'(CAPACITY)) begin
                            o_rsp.done = 1'b1;
                            o_rsp.ovf  = 1'b1;
                        end else begin
                            n_cnt = r_cnt + CW'(1);
                            if (r_cnt == '0) begin
                                we         = 1'b1;
                                waddr      = '0;
                                wdata      = i_value;
                                o_rsp.done = 1'b1;
                            end else begin
                                n_i   = AW'(r_cnt);
                                raddr = (AW'(r_cnt) - AW'(1)) >> 1;
                                n_hs  = H_UP;
                            end
                        end
                    end else begin
                        if (r_cnt == '0) begin
                            o_rsp.done = 1'b1;
                            o_rsp.fail = 1'b1;
                        end else begin
                            raddr = '0;
                            n_hs  = H_TOP;
                        end
                    end
                end
            end
            H_UP: begin
                // rdata holds the parent of the hole at r_i.
                we = 1'b1;
                if (rdata >= r_v) begin
                    o_rsp.done = 1'b1;
                    n_hs       = H_IDLE;
                end else begin
                    wdata = rdata;
                    n_i   = par_i;
                    if (par_i == '0) begin
                        n_hs = H_PUT;
                    end else begin
                        raddr = par_p;
                    end
                end
            end
            H_PUT: begin
                we         = 1'b1;
                o_rsp.done = 1'b1;
                n_hs       = H_IDLE;
            end
            H_TOP: begin
                if (rdata != r_v) begin
                    o_rsp.done = 1'b1;
                    o_rsp.fail = 1'b1;
                    n_hs       = H_IDLE;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        o_rsp.done = 1'b1;
                        n_hs       = H_IDLE;
                    end else begin
                        raddr = AW'(r_cnt - CW'(1));
                        n_hs  = H_LAST;
                    end
                end
            end
            H_LAST: begin
                // The former last element becomes the value to sink from the root.
                n_v = rdata;
                n_i = '0;
                if (cnt_x <= XW'(1)) begin
                    we         = 1'b1;
                    waddr      = '0;
                    wdata      = rdata;
                    o_rsp.done = 1'b1;
                    n_hs       = H_IDLE;
                end else begin
                    raddr = AW'(1);
                    n_hs  = H_C1;
                end
            end
            H_C1, H_C2: begin
                n_cv = rdata;
                if (r_hs == H_C1 && c1_x < cnt_x) begin
                    raddr = c1_x[AW-1:0];
                    n_hs  = H_C2;
                end else if (best_v <= r_v) begin
                    we         = 1'b1;
                    o_rsp.done = 1'b1;
                    n_hs       = H_IDLE;
                end else begin
                    we    = 1'b1;
                    wdata = best_v;
                    n_i   = best_i;
                    if (nc_x >= cnt_x) begin
                        n_hs = H_PUT;
                    end else begin
                        raddr = nc_x[AW-1:0];
                        n_hs  = H_C1;
                    end
                end
            end
            default: begin
                n_hs = H_IDLE;
            end
        endcase
    end

endmodule

// ----- verif/container_order_classifier_test.sv -----
// Self-checking testbench for the container order classifier.
`timescale 1ns / 1ps

module container_order_classifier_test;
    import coc_pkg::*;

    localparam int CAP = 1024;

    // Kinds of container used to build well-formed traces.
    localparam int KIND_STACK = 0;
    localparam int KIND_QUEUE = 1;
    localparam int KIND_HEAP  = 2;

    typedef struct packed {
        t_verdict verdict;
        logic     trace_end;
        logic     overflow;
    } t_outcome;

    typedef struct packed {
        logic        func;
        logic [15:0] value;
        logic        last;
        logic        typed;
        t_outcome    outcome;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [0] func, [16:1] value, [23:17] zero
    logic        s_axis_tlast;   // last operation of the trace
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [2:0] verdict, [3] overflow, [7:4] zero
    logic        m_axis_tlast;   // trace_end

    container_order_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Shadow containers of the predictor.
    logic [15:0] lifo_mem [CAP];
    logic [15:0] fifo_mem [CAP];
    logic [15:0] heap_mem [CAP];
    int          lifo_cnt;
    int          fifo_rd;
    int          fifo_wr;
    int          fifo_cnt;
    int          heap_cnt;
    logic [2:0]  alive;
    logic        dropped;

    t_outcome    pending_verdicts[$];
    int          mismatches;
    int          sender_idle_pct;
    int          receiver_stall_pct;
    int          hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous bound on the whole run.
    initial begin
        #40ms;
        $display("container_order_classifier test failed");
        $finish;
    end

    task automatic clear_shadow();
        lifo_cnt = 0;
        fifo_rd  = 0;
        fifo_wr  = 0;
        fifo_cnt = 0;
        heap_cnt = 0;
        alive    = 3'b111;
        dropped  = 1'b0;
    endtask

    task automatic heap_push(input logic [15:0] v);
        int i;
        int p;
        i = heap_cnt;
        heap_cnt++;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (heap_mem[p] >= v) break;
            heap_mem[i] = heap_mem[p];
            i = p;
        end
        heap_mem[i] = v;
    endtask

    task automatic heap_pop();
        logic [15:0] v;
        int i;
        int c;
        i = 0;
        heap_cnt--;
        if (heap_cnt != 0) begin
            v = heap_mem[heap_cnt];
            forever begin
                c = 2 * i + 1;
                if (c >= heap_cnt) break;
                if (c + 1 < heap_cnt && heap_mem[c + 1] > heap_mem[c]) c++;
                if (heap_mem[c] <= v) break;
                heap_mem[i] = heap_mem[c];
                i = c;
            end
            heap_mem[i] = v;
        end
    endtask

    // Applies one operation to the shadow containers and returns the verdict
    // the block must report for it.
    task automatic classify_op(input logic func, input logic [15:0] v, input logic last,
                               output t_outcome res);
        int n;
        if (func == FUNC_PUSH) begin
            if (alive[OK_STACK]) begin
                if (lifo_cnt >= CAP) dropped = 1'b1;
                else begin
                    lifo_mem[lifo_cnt] = v;
                    lifo_cnt++;
                end
            end
            if (alive[OK_FIFO]) begin
                if (fifo_cnt >= CAP) dropped = 1'b1;
                else begin
                    fifo_mem[fifo_wr] = v;
                    fifo_wr = (fifo_wr + 1) % CAP;
                    fifo_cnt++;
                end
            end
            if (alive[OK_HEAP]) begin
                if (heap_cnt >= CAP) dropped = 1'b1;
                else heap_push(v);
            end
        end else begin
            if (alive[OK_STACK]) begin
                if (lifo_cnt == 0 || lifo_mem[lifo_cnt - 1] != v) alive[OK_STACK] = 1'b0;
                else lifo_cnt--;
            end
            if (alive[OK_FIFO]) begin
                if (fifo_cnt == 0 || fifo_mem[fifo_rd] != v) alive[OK_FIFO] = 1'b0;
                else begin
                    fifo_rd = (fifo_rd + 1) % CAP;
                    fifo_cnt--;
                end
            end
            if (alive[OK_HEAP]) begin
                if (heap_cnt == 0 || heap_mem[0] != v) alive[OK_HEAP] = 1'b0;
                else heap_pop();
            end
        end
        n = alive[0] + alive[1] + alive[2];
        if (n == 0) res.verdict = VERDICT_IMPOSSIBLE;
        else if (n > 1) res.verdict = VERDICT_NOT_SURE;
        else if (alive[OK_STACK]) res.verdict = VERDICT_STACK;
        else if (alive[OK_FIFO]) res.verdict = VERDICT_QUEUE;
        else res.verdict = VERDICT_PRIO_QUEUE;
        res.trace_end = last;
        res.overflow  = dropped;
        if (last) clear_shadow();
    endtask

    // Offers one operation and waits until the block takes it. The caller
    // is at a rising edge, so every assignment lands in its own time step.
    task automatic send_op(input logic func, input logic [15:0] v, input logic last,
                           input logic typed, input t_outcome typed_res);
        t_outcome res;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, v, func};
        s_axis_tlast  <= last;
        // tready only moves at rising edges, so it is stable at the falling one.
        forever begin
            @(negedge i_clk);
            if (s_axis_tready) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        classify_op(func, v, last, res);
        pending_verdicts.push_back(typed ? typed_res : res);
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // Builds a trace that one kind of container could produce, with a share
    // of pops that break it. Narrow traces use values 0..3 so that several
    // containers stay consistent for a while.
    task automatic run_trace(input int kind, input int len, input bit narrow,
                             input int push_pct, input int noise_pct);
        logic [15:0] pool[$];
        logic [15:0] v;
        logic        func;
        t_outcome    none;
        int          k;
        none = '0;
        for (int n = 0; n < len; n++) begin
            func = (pool.size() == 0 && $urandom_range(99) < 85) ||
                   $urandom_range(99) < push_pct ? FUNC_PUSH : FUNC_POP;
            v = narrow ? 16'($urandom_range(3)) : 16'($urandom_range(65535));
            if (func == FUNC_PUSH) begin
                if (pool.size() < CAP) pool.push_back(v);
            end else if (pool.size() != 0 && $urandom_range(99) >= noise_pct) begin
                if (kind == KIND_STACK) begin
                    v = pool.pop_back();
                end else if (kind == KIND_QUEUE) begin
                    v = pool.pop_front();
                end else begin
                    k = 0;
                    foreach (pool[j]) if (pool[j] > pool[k]) k = j;
                    v = pool[k];
                    pool.delete(k);
                end
            end
            send_op(func, v, n == len - 1, 1'b0, none);
        end
    endtask

    // Receiver: random stalls, a long hold-off on request, and the check of
    // every result transaction against the oldest expectation.
    initial begin
        t_outcome want;
        t_outcome got;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= $urandom_range(99) >= receiver_stall_pct;
            end
            @(negedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got.verdict   = t_verdict'(m_axis_tdata[2:0]);
                got.overflow  = m_axis_tdata[3];
                got.trace_end = m_axis_tlast;
                if (pending_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: verdict %0d end %0b ovf %0b",
                                 got.verdict, got.trace_end, got.overflow);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: verdict %0d/%0d end %0b/%0b ovf %0b/%0b",
                                     want.verdict, got.verdict, want.trace_end,
                                     got.trace_end, want.overflow, got.overflow);
                    end
                end
            end
        end
    end

    // Directed operations; a typed expectation only where it is obvious.
    localparam t_row DIRECTED[25] = '{
        '{FUNC_POP,  16'h0000, 1'b1, 1'b1, '{VERDICT_IMPOSSIBLE, 1'b1, 1'b0}},
        '{FUNC_PUSH, 16'hFFFF, 1'b0, 1'b1, '{VERDICT_NOT_SURE,   1'b0, 1'b0}},
        '{FUNC_POP,  16'hFFFF, 1'b1, 1'b1, '{VERDICT_NOT_SURE,   1'b1, 1'b0}},
        '{FUNC_PUSH, 16'h0001, 1'b0, 1'b0, '0},
        '{FUNC_PUSH, 16'h0002, 1'b0, 1'b0, '0},
        '{FUNC_POP,  16'h0002, 1'b0, 1'b0, '0},
        '{FUNC_POP,  16'h0001, 1'b1, 1'b0, '0},
        '{FUNC_PUSH, 16'h0005, 1'b0, 1'b0, '0},
        '{FUNC_PUSH, 16'h0003, 1'b0, 1'b0, '0},
        '{FUNC_POP,  16'h0005, 1'b0, 1'b0, '0},
        '{FUNC_POP,  16'h0003, 1'b1, 1'b0, '0},
        '{FUNC_PUSH, 16'h0001, 1'b0, 1'b0, '0},
        '{FUNC_PUSH, 16'h0002, 1'b0, 1'b0, '0},
        '{FUNC_POP,  16'h0001, 1'b1, 1'b0, '0},
        '{FUNC_PUSH, 16'h0001, 1'b0, 1'b0, '0},
        '{FUNC_PUSH, 16'h0003, 1'b0, 1'b0, '0},
        '{FUNC_PUSH, 16'h0002, 1'b0, 1'b0, '0},
        '{FUNC_POP,  16'h0003, 1'b0, 1'b0, '0},
        '{FUNC_POP,  16'h0002, 1'b0, 1'b0, '0},
        '{FUNC_POP,  16'h0001, 1'b1, 1'b0, '0},
        '{FUNC_PUSH, 16'h0003, 1'b0, 1'b0, '0},
        '{FUNC_PUSH, 16'h0001, 1'b0, 1'b0, '0},
        '{FUNC_PUSH, 16'h0002, 1'b0, 1'b0, '0},
        '{FUNC_POP,  16'h0002, 1'b0, 1'b0, '0},
        '{FUNC_POP,  16'h0000, 1'b1, 1'b0, '0}
    };

    initial begin
        int idle_s[4];
        int idle_r[4];
        idle_s = '{0, 66, 0, 26};
        idle_r = '{0, 0, 66, 26};
        mismatches         = 0;
        hold_cycles        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        clear_shadow();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[r])
            send_op(DIRECTED[r].func, DIRECTED[r].value, DIRECTED[r].last,
                    DIRECTED[r].typed, DIRECTED[r].outcome);

        // Overflow: every container fills up and the extra pushes at the end
        // of the trace are dropped.
        run_trace(KIND_HEAP, 1030, 1'b0, 101, 0);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct    = idle_s[ph];
            receiver_stall_pct = idle_r[ph];
            if (ph == 0) begin
                // Receiver holds off long enough for the block to back up
                // while items keep coming.
                hold_cycles = 400;
                run_trace(KIND_STACK, 20, 1'b0, 60, 0);
            end
            for (int t = 0; t < 3; t++)
                run_trace($urandom_range(2), $urandom_range(1, 30), $urandom_range(1),
                          $urandom_range(40, 70), $urandom_range(99) < 30 ? 40 : 0);
            // The sender pauses until every result of this phase is back.
            wait_drained();
        end

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("container_order_classifier test passed");
        end else begin
            $display("container_order_classifier test failed");
        end
        $finish;
    end

endmodule

// ----- container_order_classifier.f -----
rtl/coc_pkg.sv
rtl/coc_ram.sv
rtl/coc_heap.sv
rtl/container_order_classifier.sv
verif/container_order_classifier_test.sv
